// ----- hw/rtl/dbtl_pkg.sv -----
`timescale 1ns / 1ps
package dbtl_pkg;

  localparam int unsigned TanCount = 28;

  // band boundary tangents, unsigned q5.16
  localparam logic [20:0] TAN_Q16 [TanCount] = '{
    21'd13036, 21'd43790, 21'd98082, 21'd329472,
    21'd6455, 21'd19880, 21'd35030, 21'd53784, 21'd79856, 21'd122609,
    21'd216043, 21'd665398,
    21'd3220, 21'd9721, 21'd16416, 21'd23449, 21'd30996, 21'd39281,
    21'd48605, 21'd59398, 21'd72308, 21'd88365, 21'd109340, 21'd138564,
    21'd183161, 21'd261634, 21'd441808, 21'd1334016
  };

  localparam logic [10:0] POLE_NORTH_M0 = 11'd112;
  localparam logic [10:0] POLE_NORTH_M1 = 11'd480;
  localparam logic [10:0] POLE_NORTH_M2 = 11'd1984;
  localparam logic [10:0] POLE_SOUTH_M0 = 11'd113;
  localparam logic [10:0] POLE_SOUTH_M1 = 11'd481;
  localparam logic [10:0] POLE_SOUTH_M2 = 11'd1985;

  localparam logic [1:0] MODE_COARSE = 2'd0;
  localparam logic [1:0] MODE_MEDIUM = 2'd1;
  localparam logic [1:0] MODE_FINE   = 2'd2;

  // item as it moves through the search stages
  typedef struct packed {
    logic        lookup;
    logic        xpos;
    logic        ypos;
    logic        zpos;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [30:0] zs;
    logic [31:0] xy;
    logic [3:0]  i;
    logic [3:0]  j;
    logic [1:0]  mode;
    logic [10:0] idx;
    logic [31:0] value;
  } dbtl_item_t;

  // item after the final band tests
  typedef struct packed {
    logic        lookup;
    logic        xpos;
    logic        ypos;
    logic        zpos;
    logic [3:0]  i;
    logic [3:0]  j;
    logic        pole;
    logic        jtop;
    logic [1:0]  mode;
    logic [10:0] idx;
    logic [31:0] value;
  } dbtl_fin_t;

  function automatic logic [4:0] mode_base(input logic [1:0] mode);
    logic [4:0] r;
    unique case (mode)
      MODE_COARSE: r = 5'd0;
      MODE_MEDIUM: r = 5'd4;
      default:     r = 5'd12;
    endcase
    return r;
  endfunction

  function automatic logic [20:0] tan_q16(input logic [4:0] idx);
    logic [20:0] r;
    r = '0;
    for (int k = 0; k < TanCount; k++) begin
      if (idx == 5'(k)) r = TAN_Q16[k];
    end
    return r;
  endfunction

  // rounded tangent squared, folded per entry at elaboration
  function automatic logic [24:0] tsq_q16(input logic [4:0] idx);
    logic [24:0] r;
    r = '0;
    for (int k = 0; k < TanCount; k++) begin
      if (idx == 5'(k)) begin
        r = 25'((64'(TAN_Q16[k]) * 64'(TAN_Q16[k]) + 64'd32768) >> 16);
      end
    end
    return r;
  endfunction

  function automatic logic [56:0] lat_lhs(input logic [30:0] zs);
    return {10'b0, zs, 16'b0};
  endfunction

  function automatic logic [56:0] lat_rhs(input logic [4:0] idx, input logic [31:0] xy);
    return 57'(tsq_q16(idx)) * 57'(xy);
  endfunction

  function automatic logic [36:0] lon_lhs(input logic [15:0] ay);
    return {5'b0, ay, 16'b0};
  endfunction

  function automatic logic [36:0] lon_rhs(input logic [4:0] idx, input logic [15:0] ax);
    return 37'(tan_q16(idx)) * 37'(ax);
  endfunction

  function automatic logic [10:0] pole_bin(input logic [1:0] mode, input logic north);
    logic [10:0] r;
    unique case (mode)
      MODE_COARSE: r = north ? POLE_NORTH_M0 : POLE_SOUTH_M0;
      MODE_MEDIUM: r = north ? POLE_NORTH_M1 : POLE_SOUTH_M1;
      default:     r = north ? POLE_NORTH_M2 : POLE_SOUTH_M2;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/dbtl_if.sv -----
`timescale 1ns / 1ps
interface dbtl_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] dir_x;
  logic [15:0] dir_y;
  logic [15:0] dir_z;
  logic [10:0] entry_index;
  logic [31:0] entry_value;

  modport source (output valid, kind, dir_x, dir_y, dir_z, entry_index, entry_value,
                  input ready);
  modport sink (input valid, kind, dir_x, dir_y, dir_z, entry_index, entry_value,
                output ready);
endinterface

interface dbtl_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] bin_index;
  logic [31:0] bin_value;

  modport source (output valid, bin_index, bin_value, input ready);
  modport sink (input valid, bin_index, bin_value, output ready);
endinterface

// ----- hw/rtl/direction_bin_table_lookup.sv -----
`timescale 1ns / 1ps
// channel   dir  word
// in_ch     in   kind, dir_x, dir_y, dir_z, entry_index, entry_value
// out_ch    out  bin_index, bin_value (one per lookup, none per table write)
// cfg_wr_*  in   resolution_mode (2 bits)
//
// one word per cycle unless out_ch stalls; a lookup passes the entry, search, final and output registers
// stages: entry stage, three search steps, final band tests, then the table read
// rst clears the stage valid bits and resolution_mode; table contents stay undefined
// each stage moves when its successor is empty or moving, so bubbles absorb stalls
// table writes travel the pipe and hit the memory at the lookup read stage, keeping order
module direction_bin_table_lookup
  import dbtl_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 2048,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  dbtl_in_if.sink    in_ch,
  dbtl_out_if.source out_ch
);

  localparam int unsigned AddrWidth = $clog2(TABLE_DEPTH);

  // config register
  logic [1:0] resolution_mode;
  logic [1:0] mode_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution_mode <= MODE_COARSE;
    end else if (cfg_wr_en) begin
      resolution_mode <= cfg_wr_data;
    end
  end

  // the unused code behaves as the finest mode
  assign mode_eff = (resolution_mode == 2'd3) ? MODE_FINE : resolution_mode;

  // stage enables, back to front
  logic       v0, v1, v2, v3, v4, v5;
  logic       en0, en1, en2, en3, en4, en5;

  assign en5 = !v5 || out_ch.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign in_ch.ready = en0;

  // entry stage: magnitudes, squares, signs
  dbtl_item_t item0_next, item0, item1, item2, item3;
  logic [15:0] ax_in, ay_in, az_in;
  logic [3:0]  start;

  always_comb begin
    ax_in = in_ch.dir_x[15] ? 16'(-in_ch.dir_x) : in_ch.dir_x;
    ay_in = in_ch.dir_y[15] ? 16'(-in_ch.dir_y) : in_ch.dir_y;
    az_in = in_ch.dir_z[15] ? 16'(-in_ch.dir_z) : in_ch.dir_z;
    // search starts at the middle band
    start = (4'd2 << mode_eff) - 4'd1;
    item0_next.lookup = in_ch.kind;
    item0_next.xpos   = !in_ch.dir_x[15] && (in_ch.dir_x != 16'd0);
    item0_next.ypos   = !in_ch.dir_y[15] && (in_ch.dir_y != 16'd0);
    item0_next.zpos   = !in_ch.dir_z[15] && (in_ch.dir_z != 16'd0);
    item0_next.ax     = ax_in;
    item0_next.ay     = ay_in;
    item0_next.zs     = 31'(32'(az_in) * 32'(az_in));
    item0_next.xy     = 32'(ax_in) * 32'(ax_in) + 32'(ay_in) * 32'(ay_in);
    item0_next.i      = start;
    item0_next.j      = start;
    item0_next.mode   = mode_eff;
    item0_next.idx    = in_ch.entry_index;
    item0_next.value  = in_ch.entry_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en0) begin
      v0 <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      item0 <= item0_next;
    end
  end

  // binary search, one halving per stage; finer modes use more of the stages
  dbtl_step u_step0 (
    .clk(clk), .rst(rst), .en(en1), .step(2'd0),
    .in_valid(v0), .in_item(item0), .out_valid(v1), .out_item(item1)
  );

  dbtl_step u_step1 (
    .clk(clk), .rst(rst), .en(en2), .step(2'd1),
    .in_valid(v1), .in_item(item1), .out_valid(v2), .out_item(item2)
  );

  dbtl_step u_step2 (
    .clk(clk), .rst(rst), .en(en3), .step(2'd2),
    .in_valid(v2), .in_item(item2), .out_valid(v3), .out_item(item3)
  );

  // final band tests; the top band bound is checked in parallel for the pole case
  dbtl_fin_t  fin_next, fin;
  logic [4:0] base3;
  logic [3:0] top3;
  logic       lat_gt, lat_gt_top, lon_gt, lon_gt_top;
  logic [3:0] i_fin, j_fin;

  always_comb begin
    base3      = mode_base(item3.mode);
    top3       = 4'((5'd4 << item3.mode) - 5'd1);
    lat_gt     = lat_lhs(item3.zs) > lat_rhs(base3 + 5'(item3.i), item3.xy);
    lat_gt_top = lat_lhs(item3.zs) > lat_rhs(base3 + 5'(top3), item3.xy);
    lon_gt     = lon_lhs(item3.ay) > lon_rhs(base3 + 5'(item3.j), item3.ax);
    lon_gt_top = lon_lhs(item3.ay) > lon_rhs(base3 + 5'(top3), item3.ax);
    i_fin      = item3.i + 4'(lat_gt);
    j_fin      = item3.j + 4'(lon_gt);
    fin_next.lookup = item3.lookup;
    fin_next.xpos   = item3.xpos;
    fin_next.ypos   = item3.ypos;
    fin_next.zpos   = item3.zpos;
    fin_next.i      = i_fin;
    fin_next.j      = j_fin;
    fin_next.pole   = (i_fin == top3) && lat_gt_top;
    fin_next.jtop   = (j_fin == top3) && lon_gt_top;
    fin_next.mode   = item3.mode;
    fin_next.idx    = item3.idx;
    fin_next.value  = item3.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      fin <= fin_next;
    end
  end

  // bin index from bands, quadrant and pole
  logic [5:0]  tl;
  logic [5:0]  row_band;
  logic [11:0] row;
  logic [6:0]  col;
  logic [10:0] bin;

  always_comb begin
    tl       = 6'd4 << fin.mode;
    row_band = fin.zpos ? tl - 6'(fin.i) - 6'd1 : tl + 6'(fin.i) - 6'd1;
    row      = 12'(row_band) << (3'd4 + 3'(fin.mode));
    if (fin.jtop) begin
      col = fin.ypos ? 7'(tl) : 7'(3 * tl);
    end else if (fin.j == 4'd0) begin
      col = fin.xpos ? 7'd0 : 7'(2 * tl);
    end else if (fin.ypos) begin
      col = fin.xpos ? 7'(fin.j) : 7'(2 * tl) - 7'(fin.j);
    end else begin
      col = fin.xpos ? 7'(4 * tl) - 7'(fin.j) : 7'(2 * tl) + 7'(fin.j);
    end
    bin = fin.pole ? pole_bin(fin.mode, fin.zpos) : 11'(row + 12'(col));
  end

  // value table: writes and lookups share this stage so order is kept
  logic [VALUE_WIDTH-1:0] value_table [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data;
  logic [10:0]            bin_out;

  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      if (fin.lookup) begin
        rd_data <= value_table[AddrWidth'(bin)];
      end else begin
        value_table[AddrWidth'(fin.idx)] <= VALUE_WIDTH'(fin.value);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      bin_out <= bin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= v4 && fin.lookup;
    end
  end

  assign out_ch.valid     = v5;
  assign out_ch.bin_index = bin_out;
  assign out_ch.bin_value = 32'(rd_data);

  // no bin lies beyond the south pole of the finest mode
  a_bin_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.bin_index <= POLE_SOUTH_M2)
    else $error("bin index out of range");

  // an empty entry stage always takes a word
  a_entry_ready: assert property (@(posedge clk) disable iff (rst)
    !v0 |-> in_ch.ready)
    else $error("entry stage empty but not ready");

  // the pole case only arises in the top latitude band
  a_pole_band: assert property (@(posedge clk) disable iff (rst)
    (v4 && fin.pole) |-> (6'(fin.i) == (6'd4 << fin.mode) - 6'd1))
    else $error("pole flagged below top band");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(bin_out)))
    else $error("stalled result changed");

endmodule

// ----- hw/rtl/dbtl_step.sv -----
`timescale 1ns / 1ps
module dbtl_step
  import dbtl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [1:0] step,
  input  logic       in_valid,
  input  dbtl_item_t in_item,
  output logic       out_valid,
  output dbtl_item_t out_item
);

  logic       active;
  logic [3:0] stride;
  logic [4:0] base;
  logic       lat_lt;
  logic       lon_lt;
  dbtl_item_t item_next;

  always_comb begin
    active = (step <= in_item.mode);
    stride = 4'd1 << (in_item.mode - step);
    base   = mode_base(in_item.mode);
    lat_lt = lat_lhs(in_item.zs) < lat_rhs(base + 5'(in_item.i), in_item.xy);
    lon_lt = lon_lhs(in_item.ay) < lon_rhs(base + 5'(in_item.j), in_item.ax);
    item_next = in_item;
    if (active) begin
      item_next.i = lat_lt ? in_item.i - stride : in_item.i + stride;
      item_next.j = lon_lt ? in_item.j - stride : in_item.j + stride;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule
